FILE: src/integer_nth_root_assert.svh
// Assertion macros used by the checker file of the integer nth root block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef INTEGER_NTH_ROOT_ASSERT_SVH
`define INTEGER_NTH_ROOT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/nrt_pkg.sv
// Package for the integer nth root block: fixed widths, degree limits and types.
// Used by every module of the block; depends on nothing.
package nrt_pkg;

	localparam int ROOT_BITS   = 32;
	localparam int DEGREE_BITS = 7;
	localparam int MUL_BITS    = 32;
	localparam int IN_BITS     = 64;

	localparam logic [DEGREE_BITS-1:0] MIN_DEGREE = 7'd2;
	localparam logic [DEGREE_BITS-1:0] MAX_DEGREE = 7'd64;

	typedef logic [DEGREE_BITS-1:0]  degree_t;
	typedef logic [ROOT_BITS-1:0]    root_t;
	typedef logic [MUL_BITS-1:0]     mul_op_t;
	typedef logic [2*MUL_BITS-1:0]   mul_prod_t;

	// Limits the requested degree to the supported range.
	function automatic degree_t clamp_degree(input degree_t d);
		degree_t r;
		if (d < MIN_DEGREE) begin
			r = MIN_DEGREE;
		end else if (d > MAX_DEGREE) begin
			r = MAX_DEGREE;
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

FILE: src/nrt_mul.sv
// Shared 32 x 32 unsigned multiplier with a registered product.
// Depends on nrt_pkg for the operand and product types.
module nrt_mul (
	input  logic              clk,
	input  logic              en,
	input  nrt_pkg::mul_op_t  a,
	input  nrt_pkg::mul_op_t  b,
	output nrt_pkg::mul_prod_t p
);
	import nrt_pkg::*;

	mul_prod_t prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= mul_prod_t'(a) * mul_prod_t'(b);
		end
	end

	assign p = prod_q;

endmodule

FILE: src/integer_nth_root.sv
// Integer nth root: returns floor(radicand ^ (1/degree)) for a radicand of up to 64 bits
// and a degree clamped to 2..64. The root is built one bit at a time from bit 31 down;
// each trial bit raises its candidate to the degree by repeated multiplication on one
// shared 32 x 32 multiplier, dropping out as soon as a partial power exceeds the radicand.
// Each multiplication passes through ST_MLO, then ST_MHI only when the running power is
// wider than 32 bits, then ST_CHK; each trial bit adds one setup state, ST_START.
// The block takes one word at a time: in_ready is high only while idle, and the result
// word stays on root until it is taken. Depends on nrt_pkg and nrt_mul.
module integer_nth_root #(
	parameter int RADICAND_WIDTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [nrt_pkg::IN_BITS-1:0]     radicand,
	input  nrt_pkg::degree_t                degree,
	output logic                            out_valid,
	input  logic                            out_ready,
	output nrt_pkg::root_t                  root
);
	import nrt_pkg::*;

	localparam int PROD_BITS = 3 * MUL_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_MLO   = 3'd2;
	localparam logic [2:0] ST_MHI   = 3'd3;
	localparam logic [2:0] ST_CHK   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]                 state_q;
	logic [RADICAND_WIDTH-1:0]  rad_q;
	logic [RADICAND_WIDTH-1:0]  acc_q;
	degree_t                    deg_q;
	degree_t                    cnt_q;
	logic [4:0]                 bit_q;
	root_t                      root_q;
	logic                       hi_q;
	mul_prod_t                  lo_q;

	root_t                      cand;
	logic [IN_BITS-1:0]         acc_ext;
	logic [IN_BITS-1:0]         rad_ext;
	logic [PROD_BITS-1:0]       total;
	logic                       over;
	degree_t                    cnt_next;
	logic                       mul_en;
	mul_op_t                    mul_a;
	mul_prod_t                  mul_p;

	assign cand    = root_q | (root_t'(1) << bit_q);
	assign acc_ext = IN_BITS'(acc_q);
	assign rad_ext = IN_BITS'(rad_q);

	// The high partial product, when there is one, sits in the multiplier output.
	assign total = hi_q ? ({mul_p, {MUL_BITS{1'b0}}} + PROD_BITS'(lo_q))
	                    : PROD_BITS'(mul_p);
	assign over     = total > PROD_BITS'(rad_ext);
	assign cnt_next = cnt_q + degree_t'(1);

	always_comb begin
		mul_en = 1'b0;
		mul_a  = acc_ext[MUL_BITS-1:0];
		case (state_q)
			ST_MLO: begin
				mul_en = 1'b1;
				mul_a  = acc_ext[MUL_BITS-1:0];
			end
			ST_MHI: begin
				mul_en = 1'b1;
				mul_a  = acc_ext[IN_BITS-1:MUL_BITS];
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	nrt_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (cand),
		.p   (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rad_q   <= '0;
			acc_q   <= '0;
			deg_q   <= MIN_DEGREE;
			bit_q   <= '0;
			cnt_q   <= '0;
			hi_q    <= 1'b0;
			lo_q    <= '0;
			root_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rad_q   <= radicand[RADICAND_WIDTH-1:0];
						deg_q   <= clamp_degree(degree);
						bit_q   <= 5'(ROOT_BITS - 1);
						root_q  <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					// The first power is the candidate itself.
					acc_q <= RADICAND_WIDTH'(cand);
					cnt_q <= degree_t'(1);
					if (IN_BITS'(cand) > rad_ext) begin
						if (bit_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							bit_q <= bit_q - 5'd1;
						end
					end else begin
						state_q <= ST_MLO;
					end
				end
				ST_MLO: begin
					hi_q <= 1'b0;
					if (acc_ext[IN_BITS-1:MUL_BITS] != '0) begin
						state_q <= ST_MHI;
					end else begin
						state_q <= ST_CHK;
					end
				end
				ST_MHI: begin
					lo_q    <= mul_p;
					hi_q    <= 1'b1;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (over || (cnt_next == deg_q)) begin
						if (!over) begin
							root_q <= cand;
						end
						if (bit_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							bit_q   <= bit_q - 5'd1;
							state_q <= ST_START;
						end
					end else begin
						acc_q   <= total[RADICAND_WIDTH-1:0];
						cnt_q   <= cnt_next;
						state_q <= ST_MLO;
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign root      = root_q;

endmodule

FILE: src/nrt_checker.sv
// Port-level checker for the integer nth root block, bound to the top level.
// Depends on nrt_pkg and the macros in integer_nth_root_assert.svh.
module nrt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input nrt_pkg::root_t root
);
	import nrt_pkg::*;

	`include "integer_nth_root_assert.svh"

	// A stalled result word must hold.
	`NRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(root), "result word changed while stalled")

	// The block never takes a new word while a result is pending.
	`NRT_ASSERT_NOW(a_busy_while_out, out_valid, !in_ready, "input ready while result pending")

	// An accepted word cannot produce its result in the following cycle.
	`NRT_ASSERT_NEXT(a_no_instant, in_valid && in_ready, !out_valid && !in_ready, "result or ready right after accept")

	// Once the result is taken, the block is ready again.
	`NRT_ASSERT_NEXT(a_back_idle, out_valid && out_ready, in_ready && !out_valid, "not idle after result taken")

endmodule

bind integer_nth_root nrt_checker u_nrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.root      (root)
);

FILE: tb/sv/integer_nth_root_tb.sv
// Self-checking testbench for integer_nth_root: a short table of directed words, then
// random words biased toward exact powers and their neighbors, checked against a predictor.
// Depends on nrt_pkg and the integer_nth_root RTL.
`timescale 1ns / 100ps

module integer_nth_root_tb;
	import nrt_pkg::*;

	localparam int RAD_WIDTH = 64;
	localparam logic [63:0] RAD_MASK = {64{1'b1}} >> (64 - RAD_WIDTH);
	localparam int N_DIRECTED = 23;
	localparam int N_RANDOM = 270;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic [63:0] rad;
		degree_t     deg;
		bit          known;
		root_t       want;
	} probe_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] radicand;
	degree_t     degree;
	logic        out_valid;
	logic        out_ready;
	root_t       root;

	root_t pending_roots[$];
	int    fail_count = 0;
	int    words_sent = 0;
	int    results_seen = 0;
	int    power_words = 0;
	int    clamped_words = 0;
	bit    quiet_phase = 1'b0;

	// Rows with known set carry a root that is obvious from the operands; the rest
	// are resolved by the predictor.
	probe_t directed_probes [N_DIRECTED] = '{
		'{64'd0,                     7'd2,   1'b1, 32'd0},
		'{64'd0,                     7'd64,  1'b1, 32'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF,   7'd2,   1'b1, 32'hFFFF_FFFF},
		'{64'hFFFF_FFFF_FFFF_FFFF,   7'd64,  1'b1, 32'd1},
		'{64'hFFFF_FFFF_FFFF_FFFF,   7'd127, 1'b1, 32'd1},
		'{64'hFFFF_FFFF_FFFF_FFFF,   7'd0,   1'b1, 32'hFFFF_FFFF},
		'{64'd31,                    7'd1,   1'b1, 32'd5},
		'{64'd31,                    7'd2,   1'b1, 32'd5},
		'{64'd1,                     7'd0,   1'b1, 32'd1},
		'{64'd1,                     7'd65,  1'b1, 32'd1},
		'{64'hFFFF_FFFE_0000_0001,   7'd2,   1'b1, 32'hFFFF_FFFF},
		'{64'hFFFF_FFFE_0000_0000,   7'd2,   1'b1, 32'hFFFF_FFFE},
		'{64'h8000_0000_0000_0000,   7'd63,  1'b1, 32'd2},
		'{64'h7FFF_FFFF_FFFF_FFFF,   7'd63,  1'b1, 32'd1},
		'{64'h8000_0000_0000_0000,   7'd64,  1'b1, 32'd1},
		'{64'h8000_0000_0000_0000,   7'd3,   1'b1, 32'h0020_0000},
		'{64'd1_000_000_000_000,     7'd3,   1'b1, 32'd10000},
		'{64'd999_999_999_999,       7'd3,   1'b1, 32'd9999},
		'{64'd3,                     7'd2,   1'b1, 32'd1},
		'{64'd4,                     7'd2,   1'b1, 32'd2},
		'{64'hAAAA_AAAA_5555_5555,   7'd42,  1'b0, 32'd0},
		'{64'h5555_5555_AAAA_AAAA,   7'd5,   1'b0, 32'd0},
		'{64'hFFFF_FFFF_FFFF_FFFF,   7'd32,  1'b0, 32'd0}
	};

	integer_nth_root #(
		.RADICAND_WIDTH(RAD_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.radicand  (radicand),
		.degree    (degree),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.root      (root)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic int eff_degree(input degree_t d);
		if (d < 7'd2) return 2;
		if (d > 7'd64) return 64;
		return int'(d);
	endfunction

	// Bitwise root search; a partial power above the limit rejects the trial bit.
	function automatic root_t predict_root(input logic [63:0] rad, input degree_t deg);
		logic [63:0]  lim;
		logic [127:0] pw;
		logic [63:0]  cand;
		root_t        r;
		int           n;
		bit           fits;
		lim = rad & RAD_MASK;
		n = eff_degree(deg);
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			cand = {32'd0, r | (32'd1 << b)};
			pw = 128'd1;
			fits = 1'b1;
			for (int k = 0; k < n && fits; k++) begin
				pw = pw * cand;
				if (pw > {64'd0, lim}) fits = 1'b0;
			end
			if (fits) r = r | (32'd1 << b);
		end
		return r;
	endfunction

	task automatic note_failure(input string what, input root_t want, input root_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("MISMATCH %0t: %s, expected %h, got %h", $realtime, what, want, got);
	endtask

	task automatic send_word(input logic [63:0] rad, input degree_t deg, input bit known,
			input root_t want);
		int gap;
		bit late;
		gap = quiet_phase ? 0 : $urandom_range(0, 4);
		late = 1'($urandom_range(0, 1));
		if (gap != 0) begin
			in_valid <= 1'b0;
			// Sometimes hold off until the block is idle, so the gap falls there.
			if (late) begin
				do @(posedge clk); while (!in_ready);
			end
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		radicand <= rad;
		degree <= deg;
		do @(posedge clk); while (!in_ready);
		pending_roots.push_back(known ? want : predict_root(rad, deg));
		words_sent++;
		if (deg < 7'd2 || deg > 7'd64) clamped_words++;
	endtask

	initial begin : result_sink
		int    hold;
		bit    late;
		root_t want;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = quiet_phase ? 0 : $urandom_range(0, 4);
			late = 1'($urandom_range(0, 1));
			if (hold != 0) begin
				out_ready <= 1'b0;
				if (late) begin
					do @(posedge clk); while (!out_valid);
				end
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			results_seen++;
			if (pending_roots.size() == 0) begin
				note_failure("result word with nothing outstanding", '0, root);
			end else begin
				want = pending_roots.pop_front();
				if (root !== want) note_failure("root", want, root);
			end
		end
	end

	initial begin : stimulus
		logic [63:0]  rad;
		logic [127:0] pw;
		degree_t      deg;
		root_t        top;
		root_t        base;
		int           n;
		int           kind;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		radicand <= '0;
		degree <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_probes[i])
			send_word(directed_probes[i].rad, directed_probes[i].deg,
				directed_probes[i].known, directed_probes[i].want);

		for (int i = 0; i < N_RANDOM; i++) begin
			quiet_phase = (i % 90) >= 65;
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: deg = degree_t'($urandom_range(2, 12));
				6, 7:             deg = degree_t'($urandom_range(13, 64));
				8:                deg = degree_t'($urandom_range(65, 127));
				default:          deg = degree_t'($urandom_range(0, 127));
			endcase
			kind = $urandom_range(0, 9);
			if (kind <= 4) begin
				// Exact power of a random base, or one of its neighbors.
				n = eff_degree(deg);
				top = predict_root(64'hFFFF_FFFF_FFFF_FFFF, deg);
				base = $urandom_range(0, top);
				pw = 128'd1;
				for (int k = 0; k < n; k++) pw = pw * {96'd0, base};
				rad = pw[63:0] + 64'($signed($urandom_range(0, 2)) - 1);
				power_words++;
			end else if (kind <= 6) begin
				rad = {$urandom, $urandom};
			end else if (kind <= 8) begin
				rad = {$urandom, $urandom} >> $urandom_range(0, 63);
			end else begin
				rad = 64'($urandom_range(0, 3));
			end
			send_word(rad, deg, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_roots.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_roots.size() != 0)
			note_failure("root word never returned", pending_roots[0], '0);

		$display("Sent %0d words (%0d near exact powers, %0d with clamped degree).",
			words_sent, power_words, clamped_words);
		$display("Checked %0d result words, %0d failures.", results_seen, fail_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin : watchdog
		#60_000_000;
		$display("Timeout waiting for the block.");
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/nrt_pkg.sv
src/nrt_mul.sv
src/integer_nth_root.sv
src/nrt_checker.sv
tb/sv/integer_nth_root_tb.sv
